>>> hw/rtl/spi_pkg.sv
// shared constants for the segment / plane intersection block
package spi_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int ADDR_BITS      = 5;
	localparam int DATA_BITS      = 32;

	// register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_NORMAL_X = 3'd0,
		REG_NORMAL_Y = 3'd1,
		REG_NORMAL_Z = 3'd2,
		REG_OFFSET   = 3'd3,
		REG_EPSILON  = 3'd4
	} reg_idx_t;

	localparam logic [31:0] NORMAL_X_RST = 32'd0;
	localparam logic [31:0] NORMAL_Y_RST = 32'd65536;
	localparam logic [31:0] NORMAL_Z_RST = 32'd0;
	localparam logic [31:0] OFFSET_RST   = 32'd0;
	localparam logic [31:0] EPSILON_RST  = 32'd43;

endpackage

>>> hw/rtl/spi_front.sv
// front stages: differences, normal products and the a / b dot products
module spi_front #(
	parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] s_in [3],
	input  logic signed [COORD_BITS-1:0] e_in [3],
	input  logic signed [31:0]           normal [3],
	input  logic signed [31:0]           offset,
	output logic                         valid_s3,
	output logic signed [COORD_BITS-1:0] s_s3 [3],
	output logic signed [((COORD_BITS > 32) ? COORD_BITS : 32):0] d_s3 [3],
	output logic signed [((COORD_BITS > 32) ? COORD_BITS : 32)+34:0] a_s3,
	output logic signed [((COORD_BITS > 32) ? COORD_BITS : 32)+34:0] b_s3
);
	localparam int EW = ((COORD_BITS > 32) ? COORD_BITS : 32) + 1;
	localparam int PW = 32 + EW;
	localparam int AW = PW + 2;

	logic                         valid_s1, valid_s2;
	logic signed [COORD_BITS-1:0] s_s1 [3];
	logic signed [COORD_BITS-1:0] s_s2 [3];
	logic signed [EW-1:0]         d_s1 [3];
	logic signed [EW-1:0]         d_s2 [3];
	logic signed [EW-1:0]         w_s1 [3];
	logic signed [PW-1:0]         pa_s2 [3];
	logic signed [PW-1:0]         pb_s2 [3];

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: direction and offset-relative start
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			s_s1[k] <= s_in[k];
			d_s1[k] <= EW'(e_in[k]) - EW'(s_in[k]);
			w_s1[k] <= (k == 1) ? EW'(s_in[k]) - EW'(offset) : EW'(s_in[k]);
		end
	end

	// stage 2: one multiply per term
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			s_s2[k]  <= s_s1[k];
			d_s2[k]  <= d_s1[k];
			pa_s2[k] <= PW'(normal[k]) * PW'(w_s1[k]);
			pb_s2[k] <= PW'(normal[k]) * PW'(d_s1[k]);
		end
	end

	// stage 3: sums
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			s_s3[k] <= s_s2[k];
			d_s3[k] <= d_s2[k];
		end
		a_s3 <= -(AW'(pa_s2[0]) + AW'(pa_s2[1]) + AW'(pa_s2[2]));
		b_s3 <= AW'(pb_s2[0]) + AW'(pb_s2[1]) + AW'(pb_s2[2]);
	end

endmodule

>>> hw/rtl/spi_div_cell.sv
// one restoring division cell: settles one quotient bit for all three lanes
module spi_div_cell #(
	parameter int NW   = 100,
	parameter int AW   = 67,
	parameter int QB   = 33,
	parameter int STEP = 0,
	parameter int TW   = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  logic [3*NW-1:0] rem_in,
	input  logic [3*QB-1:0] quo_in,
	input  logic [AW-1:0]   den_in,
	input  logic [TW-1:0]   tag_in,
	output logic            valid_s1,
	output logic [3*NW-1:0] rem_s1,
	output logic [3*QB-1:0] quo_s1,
	output logic [AW-1:0]   den_s1,
	output logic [TW-1:0]   tag_s1
);
	logic [NW-1:0]   trial;
	logic [3*NW-1:0] rem_nx;
	logic [3*QB-1:0] quo_nx;

	assign trial = NW'(den_in) << STEP;

	// compare and subtract per lane
	always_comb begin
		rem_nx = rem_in;
		quo_nx = quo_in;
		for (int k = 0; k < 3; k++) begin
			if (rem_in[k*NW +: NW] >= trial) begin
				rem_nx[k*NW +: NW]  = rem_in[k*NW +: NW] - trial;
				quo_nx[k*QB + STEP] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_s1 <= rem_nx;
		quo_s1 <= quo_nx;
		den_s1 <= den_in;
		tag_s1 <= tag_in;
	end

endmodule

>>> hw/rtl/segment_plane_intersection.sv
// top level: segment / plane intersection, config registers and divider chain
// One segment is taken every cycle (busy stays low) and its result appears
// for exactly one cycle on done; the receiver cannot stall, so results must
// be taken as they come. Between input and done lie three dot-product stages,
// three decision and product stages, the divider, a chain of COORD_BITS + 1
// cells that each settle one quotient bit, and the output register.
module segment_plane_intersection #(
	parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [spi_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [spi_pkg::DATA_BITS-1:0]       pwdata,
	output logic [spi_pkg::DATA_BITS-1:0]       prdata,
	output logic                                pready,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_BITS-1:0]        start_x,
	input  logic signed [COORD_BITS-1:0]        start_y,
	input  logic signed [COORD_BITS-1:0]        start_z,
	input  logic signed [COORD_BITS-1:0]        end_x,
	input  logic signed [COORD_BITS-1:0]        end_y,
	input  logic signed [COORD_BITS-1:0]        end_z,
	output logic                                done,
	output logic                                hit,
	output logic signed [COORD_BITS-1:0]        point_x,
	output logic signed [COORD_BITS-1:0]        point_y,
	output logic signed [COORD_BITS-1:0]        point_z
);
	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int EW = ((CB > 32) ? CB : 32) + 1;
	localparam int AW = 32 + EW + 2;
	localparam int HW = AW - 32;
	localparam int NW = DW + AW;
	localparam int QB = DW;
	localparam int TW = 1 + 3 + 3 * CB;

	logic [31:0] normal_x_q, normal_y_q, normal_z_q, offset_q, epsilon_q;
	logic        wr_en;
	spi_pkg::reg_idx_t idx;

	// config port
	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = spi_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_x_q <= spi_pkg::NORMAL_X_RST;
			normal_y_q <= spi_pkg::NORMAL_Y_RST;
			normal_z_q <= spi_pkg::NORMAL_Z_RST;
			offset_q   <= spi_pkg::OFFSET_RST;
			epsilon_q  <= spi_pkg::EPSILON_RST;
		end else if (wr_en) begin
			case (idx)
				spi_pkg::REG_NORMAL_X: normal_x_q <= pwdata;
				spi_pkg::REG_NORMAL_Y: normal_y_q <= pwdata;
				spi_pkg::REG_NORMAL_Z: normal_z_q <= pwdata;
				spi_pkg::REG_OFFSET:   offset_q   <= pwdata;
				spi_pkg::REG_EPSILON:  epsilon_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			spi_pkg::REG_NORMAL_X: prdata = normal_x_q;
			spi_pkg::REG_NORMAL_Y: prdata = normal_y_q;
			spi_pkg::REG_NORMAL_Z: prdata = normal_z_q;
			spi_pkg::REG_OFFSET:   prdata = offset_q;
			spi_pkg::REG_EPSILON:  prdata = epsilon_q;
			default:               prdata = '0;
		endcase
	end

	// dot products
	logic signed [CB-1:0] s_in [3];
	logic signed [CB-1:0] e_in [3];
	logic signed [31:0]   nrm [3];
	logic                 valid_s3;
	logic signed [CB-1:0] s_s3 [3];
	logic signed [EW-1:0] d_s3 [3];
	logic signed [AW-1:0] a_s3, b_s3;

	assign s_in[0] = start_x;
	assign s_in[1] = start_y;
	assign s_in[2] = start_z;
	assign e_in[0] = end_x;
	assign e_in[1] = end_y;
	assign e_in[2] = end_z;
	assign nrm[0]  = normal_x_q;
	assign nrm[1]  = normal_y_q;
	assign nrm[2]  = normal_z_q;

	spi_front #(.COORD_BITS(CB)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.s_in     (s_in),
		.e_in     (e_in),
		.normal   (nrm),
		.offset   (offset_q),
		.valid_s3 (valid_s3),
		.s_s3     (s_s3),
		.d_s3     (d_s3),
		.a_s3     (a_s3),
		.b_s3     (b_s3)
	);

	// stage 4: magnitudes and hit decision
	logic          valid_s4, valid_s5, valid_s6;
	logic          hit_s4, hit_s5, hit_s6;
	logic [AW-1:0] am_s4, bm_s4, bm_s5, bm_s6;
	logic [DW-1:0] dm_s4 [3];
	logic [2:0]    neg_s4, neg_s5, neg_s6;
	logic signed [CB-1:0] s_s4 [3];
	logic signed [CB-1:0] s_s5 [3];
	logic signed [CB-1:0] s_s6 [3];
	logic [AW-1:0] am_c, bm_c;
	logic          hit_c;

	always_comb begin
		am_c  = a_s3[AW-1] ? AW'(-a_s3) : AW'(a_s3);
		bm_c  = b_s3[AW-1] ? AW'(-b_s3) : AW'(b_s3);
		hit_c = (b_s3 != '0) && (bm_c >= AW'(epsilon_q)) &&
			((a_s3 == '0) || ((a_s3[AW-1] == b_s3[AW-1]) && (am_c <= bm_c)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		hit_s4 <= hit_c;
		am_s4  <= am_c;
		bm_s4  <= bm_c;
		for (int k = 0; k < 3; k++) begin
			s_s4[k]   <= s_s3[k];
			dm_s4[k]  <= d_s3[k][EW-1] ? DW'(-d_s3[k]) : DW'(d_s3[k]);
			neg_s4[k] <= d_s3[k][EW-1] ^ a_s3[AW-1] ^ b_s3[AW-1];
		end
	end

	// stage 5: partial products of |d| * |a|
	logic [DW+31:0]   plo_s5 [3];
	logic [DW+HW-1:0] phi_s5 [3];

	always_ff @(posedge clk) begin
		hit_s5 <= hit_s4;
		bm_s5  <= bm_s4;
		neg_s5 <= neg_s4;
		for (int k = 0; k < 3; k++) begin
			s_s5[k]   <= s_s4[k];
			plo_s5[k] <= (DW+32)'(dm_s4[k]) * (DW+32)'(am_s4[31:0]);
			phi_s5[k] <= (DW+HW)'(dm_s4[k]) * (DW+HW)'(am_s4[AW-1:32]);
		end
	end

	// stage 6: numerator magnitude
	logic [3*NW-1:0] num_s6;

	always_ff @(posedge clk) begin
		hit_s6 <= hit_s5;
		bm_s6  <= bm_s5;
		neg_s6 <= neg_s5;
		for (int k = 0; k < 3; k++) begin
			s_s6[k]            <= s_s5[k];
			num_s6[k*NW +: NW] <= NW'(plo_s5[k]) + (NW'(phi_s5[k]) << 32);
		end
	end

	// divider chain, most significant quotient bit first
	logic            cv   [QB+1];
	logic [3*NW-1:0] crem [QB+1];
	logic [3*QB-1:0] cquo [QB+1];
	logic [AW-1:0]   cden [QB+1];
	logic [TW-1:0]   ctag [QB+1];

	assign cv[0]   = valid_s6;
	assign crem[0] = num_s6;
	assign cquo[0] = '0;
	assign cden[0] = bm_s6;
	assign ctag[0] = {hit_s6, neg_s6, s_s6[2], s_s6[1], s_s6[0]};

	for (genvar i = 0; i < QB; i++) begin : g_cell
		spi_div_cell #(
			.NW(NW), .AW(AW), .QB(QB), .STEP(QB - 1 - i), .TW(TW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (cv[i]),
			.rem_in   (crem[i]),
			.quo_in   (cquo[i]),
			.den_in   (cden[i]),
			.tag_in   (ctag[i]),
			.valid_s1 (cv[i+1]),
			.rem_s1   (crem[i+1]),
			.quo_s1   (cquo[i+1]),
			.den_s1   (cden[i+1]),
			.tag_s1   (ctag[i+1])
		);
	end

	// final step along the segment and output register
	logic [CB-1:0] pt_c [3];
	logic [CB-1:0] px_q, py_q, pz_q;
	logic          done_q, hit_q;
	logic [TW-1:0] tag_t;
	logic [CB-1:0] sk, qk;

	assign tag_t = ctag[QB];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sk = tag_t[k*CB +: CB];
			qk = cquo[QB][k*QB +: CB];
			pt_c[k] = tag_t[3*CB + k] ? (sk - qk) : (sk + qk);
			if (!tag_t[TW-1]) begin
				pt_c[k] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cv[QB];
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= tag_t[TW-1];
		px_q  <= pt_c[0];
		py_q  <= pt_c[1];
		pz_q  <= pt_c[2];
	end

	assign done    = done_q;
	assign hit     = hit_q;
	assign point_x = px_q;
	assign point_y = py_q;
	assign point_z = pz_q;

endmodule

>>> sim/testbench.sv
// testbench for the segment / plane intersection block
module testbench;

	typedef struct {
		logic signed [31:0] sx, sy, sz, ex, ey, ez;
	} segment_t;

	typedef struct {
		logic               hit;
		logic signed [31:0] px, py, pz;
	} crossing_t;

	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [spi_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [spi_pkg::DATA_BITS-1:0] pwdata = '0;
	logic [spi_pkg::DATA_BITS-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [31:0] end_x = '0, end_y = '0, end_z = '0;
	logic done, hit;
	logic signed [31:0] point_x, point_y, point_z;

	// plane copy held by the testbench
	logic signed [31:0] plane_nx = spi_pkg::NORMAL_X_RST, plane_ny = spi_pkg::NORMAL_Y_RST;
	logic signed [31:0] plane_nz = spi_pkg::NORMAL_Z_RST, plane_off = spi_pkg::OFFSET_RST;
	logic [31:0] plane_eps = spi_pkg::EPSILON_RST;

	segment_t  segments_q[$];
	crossing_t crossings_q[$];
	int  errors = 0;
	int  stalled = 0;
	int  sent = 0;
	bit  steady = 1'b0;

	segment_plane_intersection dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// exact crossing point of a segment with the configured plane
	function automatic crossing_t predict_crossing(segment_t sg);
		logic signed [127:0] s[3], d[3], w[3], n[3];
		logic signed [127:0] a, b, ab, bb, num, q;
		crossing_t r;
		bit neg;
		s[0] = sg.sx; s[1] = sg.sy; s[2] = sg.sz;
		d[0] = sg.ex - s[0]; d[1] = sg.ey - s[1]; d[2] = sg.ez - s[2];
		w[0] = s[0]; w[1] = s[1] - plane_off; w[2] = s[2];
		n[0] = plane_nx; n[1] = plane_ny; n[2] = plane_nz;
		a = -(n[0] * w[0] + n[1] * w[1] + n[2] * w[2]);
		b = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
		ab = (a < 0) ? -a : a;
		bb = (b < 0) ? -b : b;
		r = '{1'b0, 32'sd0, 32'sd0, 32'sd0};
		// parallel, zero-length or out-of-extent segments miss
		if (b == 0 || bb < $signed({96'd0, plane_eps}))
			return r;
		if (a != 0 && (((a < 0) != (b < 0)) || ab > bb))
			return r;
		r.hit = 1'b1;
		for (int k = 0; k < 3; k++) begin
			num = d[k] * a;
			neg = (num < 0) != (b < 0);
			q = ((num < 0) ? -num : num) / bb;
			if (k == 0) r.px = neg ? s[k] - q : s[k] + q;
			if (k == 1) r.py = neg ? s[k] - q : s[k] + q;
			if (k == 2) r.pz = neg ? s[k] - q : s[k] + q;
		end
		return r;
	endfunction

	// driver: offer the next pending item at the falling edge
	always @(negedge clk) begin
		if (arst_n && segments_q.size() > 0 && (steady || $urandom_range(99) >= 34)) begin
			start   <= 1'b1;
			start_x <= segments_q[0].sx; start_y <= segments_q[0].sy;
			start_z <= segments_q[0].sz; end_x <= segments_q[0].ex;
			end_y   <= segments_q[0].ey; end_z <= segments_q[0].ez;
		end else begin
			start <= 1'b0;
		end
	end

	// monitor: take accepted items and check results
	always @(posedge clk) begin
		segment_t  sg;
		crossing_t want;
		if (arst_n) begin
			if ((start && !busy) || done)
				stalled <= 0;
			else
				stalled <= stalled + 1;
			if (start && !busy) begin
				sg = '{start_x, start_y, start_z, end_x, end_y, end_z};
				crossings_q.push_back(predict_crossing(sg));
				void'(segments_q.pop_front());
				sent <= sent + 1;
			end
			if (done) begin
				if (crossings_q.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					want = crossings_q.pop_front();
					if (hit !== want.hit) begin
						$error("hit expected %0d actual %0d", want.hit, hit);
						errors++;
					end
					if (point_x !== want.px) begin
						$error("point_x expected %0d actual %0d", want.px, point_x);
						errors++;
					end
					if (point_y !== want.py) begin
						$error("point_y expected %0d actual %0d", want.py, point_y);
						errors++;
					end
					if (point_z !== want.pz) begin
						$error("point_z expected %0d actual %0d", want.pz, point_z);
						errors++;
					end
				end
			end
			if (stalled >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// register write over the config port, mirrored into the plane copy
	task automatic write_reg(spi_pkg::reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= spi_pkg::ADDR_BITS'(idx) << 2; pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			spi_pkg::REG_NORMAL_X: plane_nx = v;
			spi_pkg::REG_NORMAL_Y: plane_ny = v;
			spi_pkg::REG_NORMAL_Z: plane_nz = v;
			spi_pkg::REG_OFFSET:   plane_off = v;
			spi_pkg::REG_EPSILON:  plane_eps = v;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic set_plane(logic [31:0] nx, ny, nz, off, eps);
		write_reg(spi_pkg::REG_NORMAL_X, nx);
		write_reg(spi_pkg::REG_NORMAL_Y, ny);
		write_reg(spi_pkg::REG_NORMAL_Z, nz);
		write_reg(spi_pkg::REG_OFFSET, off);
		write_reg(spi_pkg::REG_EPSILON, eps);
	endtask

	// coordinate mix: full range, small values, and extremes
	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(9))
			0:       return 32'sh7fffffff - $urandom_range(3);
			1:       return 32'sh80000000 + $urandom_range(3);
			2, 3, 4: return $signed($urandom_range(2 * 65536 * 40)) - 65536 * 40;
			default: return $urandom;
		endcase
	endfunction

	function automatic segment_t rand_segment();
		segment_t sg;
		sg = '{rand_coord(), rand_coord(), rand_coord(),
		       rand_coord(), rand_coord(), rand_coord()};
		case ($urandom_range(9))
			0: sg.sy = plane_off;
			1: begin sg.ex = sg.sx; sg.ey = sg.sy; sg.ez = sg.sz; end
			2: sg.ey = sg.sy;
			default: ;
		endcase
		return sg;
	endfunction

	task automatic wait_drained();
		while (segments_q.size() > 0 || crossings_q.size() > 0)
			@(posedge clk);
		repeat (48) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed items on the reset plane y = 0
		segments_q.push_back('{0, -65536, 0, 0, 65536, 0});
		segments_q.push_back('{65536, 0, 3 * 65536, 0, 65536, 0});
		segments_q.push_back('{5, 7, 9, 5, 7, 9});
		segments_q.push_back('{1, 65536, 2, 9, 65536, 4});
		segments_q.push_back('{0, 65536, 0, 0, 2 * 65536, 0});
		segments_q.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000,
		                       32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
		segments_q.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
		                       32'sh80000000, 32'sh80000000, 32'sh80000000});
		segments_q.push_back('{32'sh7fffffff, -1, 32'sh80000000, 32'sh80000000, 1, -1});
		segments_q.push_back('{0, 0, 0, 0, 0, 0});
		segments_q.push_back('{3, 65536, 7, -3, -2 * 65536, 11});
		segments_q.push_back('{1, 20, 1, 2, -22, 2});
		segments_q.push_back('{-1, 0, -1, 1, 65536, 1});
		wait_drained();

		// plane settings, extremes among them; each phase ends drained
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_plane(spi_pkg::NORMAL_X_RST, spi_pkg::NORMAL_Y_RST,
				             spi_pkg::NORMAL_Z_RST, spi_pkg::OFFSET_RST, 0);
				1: set_plane(32'h80000000, 32'h7fffffff, 32'h80000000,
				             32'h7fffffff, 32'hffffffff);
				2: set_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff,
				             32'h80000000, 1);
				3: set_plane(65536, 65536, 65536, 3 * 65536, spi_pkg::EPSILON_RST);
				4: set_plane($urandom, $urandom, $urandom, $urandom, $urandom_range(255));
				5: set_plane(0, 0, 1, $urandom, $urandom);
				default: set_plane(spi_pkg::NORMAL_X_RST, spi_pkg::NORMAL_Y_RST,
				                   spi_pkg::NORMAL_Z_RST, spi_pkg::OFFSET_RST,
				                   spi_pkg::EPSILON_RST);
			endcase
			for (int i = 0; i < 235; i++)
				segments_q.push_back(rand_segment());
			steady = (ph == 3);
			wait_drained();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> segment_plane_intersection.f
hw/rtl/spi_pkg.sv
hw/rtl/spi_front.sv
hw/rtl/spi_div_cell.sv
hw/rtl/segment_plane_intersection.sv
sim/testbench.sv
